// ===== rtl/core/epi_pkg.sv =====
package epi_pkg;

   localparam int COEF_W = 18;
   localparam int ROW_W = 3 * COEF_W;
   localparam int SCALE_W = 32;
   localparam int CHI_W = 18;
   localparam int SCORE_W = 28;
   localparam int CSR_IDX_W = 3;

   localparam int PROD_W = 2 * COEF_W;
   localparam int LINE_W = PROD_W + 2;
   localparam int LINE16_W = LINE_W - 14;
   localparam int RESP_W = COEF_W + LINE_W;
   localparam int RES_W = RESP_W + 2;
   localparam int R16_W = 30;
   localparam int SQ_W = 2 * LINE16_W;
   localparam int NORM_W = SQ_W + 1;
   localparam int R2_W = 56;
   localparam int HALF_W = R2_W / 2;
   localparam int NUM_W = R2_W + SCALE_W;
   localparam int STEP_W = 5;

   localparam int POINT_INDEX_LIMIT_DEFAULT = 4096;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHI_W-1:0] CHI_MAX = '1;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd4096;
   localparam logic [CHI_W-1:0] THRESHOLD_RESET = 18'd15733;
   localparam logic [CHI_W-1:0] OFFSET_RESET = 18'd24539;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_E_ROW0 = 3'd0,
      CSR_E_ROW1 = 3'd1,
      CSR_E_ROW2 = 3'd2,
      CSR_INV_SIGMA_SQ = 3'd3,
      CSR_THRESHOLD = 3'd4,
      CSR_SCORE_OFFSET = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0] inverse_sigma_squared;
      logic [CHI_W-1:0] inlier_threshold;
      logic [CHI_W-1:0] score_offset;
   } score_cfg_type;

   typedef struct packed {
      logic [R2_W-1:0] r2;
      logic [NORM_W-1:0] norm_from;
      logic [NORM_W-1:0] norm_to;
      logic last;
   } line_entry_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL_LO = 7'b0000010,
      ST_MUL_HI = 7'b0000100,
      ST_SUM = 7'b0001000,
      ST_SAT = 7'b0010000,
      ST_DIV = 7'b0100000,
      ST_DONE = 7'b1000000
   } back_state_type;

endpackage

// ===== rtl/core/epi_if.sv =====
interface epi_req_if import epi_pkg::*; #(parameter int IDX_W = 12);
   logic valid;
   logic ready;
   logic [IDX_W-1:0] from_index;
   logic signed [COEF_W-1:0] from_x;
   logic signed [COEF_W-1:0] from_y;
   logic signed [COEF_W-1:0] from_z;
   logic signed [COEF_W-1:0] to_x;
   logic signed [COEF_W-1:0] to_y;
   logic signed [COEF_W-1:0] to_z;
   logic last_match;

   modport source (output valid, from_index, from_x, from_y, from_z, to_x, to_y, to_z,
      last_match, input ready);
   modport sink (input valid, from_index, from_x, from_y, from_z, to_x, to_y, to_z,
      last_match, output ready);
endinterface

interface epi_rsp_if import epi_pkg::*; #(parameter int IDX_W = 12);
   logic valid;
   logic ready;
   logic [IDX_W-1:0] match_index;
   logic is_inlier;
   logic [CHI_W-1:0] chi_from;
   logic [CHI_W-1:0] chi_to;
   logic [SCORE_W-1:0] score_total;
   logic score_final;

   modport source (output valid, match_index, is_inlier, chi_from, chi_to, score_total,
      score_final, input ready);
   modport sink (input valid, match_index, is_inlier, chi_from, chi_to, score_total,
      score_final, output ready);
endinterface

// ===== rtl/core/epi_fifo.sv =====
module epi_fifo import epi_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   input logic push,
   input logic [WIDTH-1:0] push_data,
   output logic full,
   input logic pop,
   output logic [WIDTH-1:0] pop_data,
   output logic not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop = pop && not_empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/epi_front.sv =====
module epi_front import epi_pkg::*; #(
   parameter int IDX_W = 12
) (
   input logic clock,
   input logic reset,
   epi_req_if.sink req_chan,
   input logic [ROW_W-1:0] e_row [3],
   output logic push,
   output line_entry_type push_entry,
   output logic [IDX_W-1:0] push_index,
   input logic queue_full
);

   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic stall;

   logic signed [COEF_W-1:0] coef [3][3];
   logic signed [COEF_W-1:0] pf [3];
   logic signed [COEF_W-1:0] pt [3];

   logic signed [PROD_W-1:0] prod_f_ff [3][3], prod_f_in [3][3];
   logic signed [PROD_W-1:0] prod_t_ff [2][3], prod_t_in [2][3];
   logic signed [COEF_W-1:0] pt1_ff [3], pt2_ff [3];
   logic signed [LINE_W-1:0] lf_ff [3], lf_in [3];
   logic signed [LINE16_W-1:0] lt16_ff [2], lt16_in [2];
   logic signed [RESP_W-1:0] resp_ff [3], resp_in [3];
   logic signed [SQ_W-1:0] sq_ff [4], sq_in [4];
   logic signed [R16_W-1:0] r16_ff, r16_in;
   logic [NORM_W-1:0] nf_ff, nf_in, nt_ff, nt_in;
   logic [NORM_W-1:0] nf5_ff, nt5_ff;
   logic [R2_W-1:0] r2_ff, r2_in;
   logic [IDX_W-1:0] idx_ff [STAGES];
   logic last_ff [STAGES];

   logic signed [LINE_W-1:0] lt_full [2];
   logic signed [LINE16_W-1:0] lf16 [2];
   logic signed [RES_W-1:0] res;
   logic signed [2*R16_W-1:0] r2_full;

   assign stall = valid_ff[STAGES-1] && queue_full;
   assign req_chan.ready = !stall;
   assign push = valid_ff[STAGES-1];
   assign push_entry = '{r2: r2_ff, norm_from: nf5_ff, norm_to: nt5_ff,
                         last: last_ff[STAGES-1]};
   assign push_index = idx_ff[STAGES-1];

   assign pf[0] = req_chan.from_x;
   assign pf[1] = req_chan.from_y;
   assign pf[2] = req_chan.from_z;
   assign pt[0] = req_chan.to_x;
   assign pt[1] = req_chan.to_y;
   assign pt[2] = req_chan.to_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coef[r][c] = $signed(e_row[r][COEF_W*c +: COEF_W]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            prod_f_in[i][k] = coef[i][k] * pf[k];
         end
      end
      for (int i = 0; i < 2; i++) begin
         for (int k = 0; k < 3; k++) begin
            prod_t_in[i][k] = pt[k] * coef[k][i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lf_in[i] = LINE_W'(prod_f_ff[i][0]) + LINE_W'(prod_f_ff[i][1])
                  + LINE_W'(prod_f_ff[i][2]);
      end
      for (int i = 0; i < 2; i++) begin
         lt_full[i] = LINE_W'(prod_t_ff[i][0]) + LINE_W'(prod_t_ff[i][1])
                    + LINE_W'(prod_t_ff[i][2]);
         lt16_in[i] = LINE16_W'(lt_full[i] >>> 14);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         resp_in[i] = pt2_ff[i] * lf_ff[i];
      end
      for (int i = 0; i < 2; i++) begin
         lf16[i] = LINE16_W'(lf_ff[i] >>> 14);
         sq_in[i] = lf16[i] * lf16[i];
         sq_in[i+2] = lt16_ff[i] * lt16_ff[i];
      end
   end

   always_comb begin
      res = RES_W'(resp_ff[0]) + RES_W'(resp_ff[1]) + RES_W'(resp_ff[2]);
      r16_in = R16_W'(res >>> 28);
      nf_in = NORM_W'(unsigned'(sq_ff[0])) + NORM_W'(unsigned'(sq_ff[1]));
      nt_in = NORM_W'(unsigned'(sq_ff[2])) + NORM_W'(unsigned'(sq_ff[3]));
      r2_full = r16_ff * r16_ff;
      r2_in = R2_W'(unsigned'(r2_full));
   end

   always_comb begin
      valid_in = {valid_ff[STAGES-2:0], req_chan.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (!stall) begin
         valid_ff <= valid_in;
      end
      if (!stall) begin
         prod_f_ff <= prod_f_in;
         prod_t_ff <= prod_t_in;
         pt1_ff <= pt;
         idx_ff[0] <= req_chan.from_index;
         last_ff[0] <= req_chan.last_match;
         lf_ff <= lf_in;
         lt16_ff <= lt16_in;
         pt2_ff <= pt1_ff;
         resp_ff <= resp_in;
         sq_ff <= sq_in;
         r16_ff <= r16_in;
         nf_ff <= nf_in;
         nt_ff <= nt_in;
         r2_ff <= r2_in;
         nf5_ff <= nf_ff;
         nt5_ff <= nt_ff;
         for (int s = 1; s < STAGES; s++) begin
            idx_ff[s] <= idx_ff[s-1];
            last_ff[s] <= last_ff[s-1];
         end
      end
   end

endmodule

// ===== rtl/core/epi_back.sv =====
module epi_back import epi_pkg::*; #(
   parameter int IDX_W = 12
) (
   input logic clock,
   input logic reset,
   input score_cfg_type cfg,
   input logic queue_valid,
   input line_entry_type queue_entry,
   input logic [IDX_W-1:0] queue_index,
   output logic pop,
   epi_rsp_if.source rsp_chan
);

   back_state_type state_ff, state_in;
   line_entry_type entry_ff;
   logic [IDX_W-1:0] index_ff;
   logic [HALF_W+SCALE_W-1:0] prod_lo_ff, prod_hi_ff;
   logic [NUM_W-1:0] num_ff, rem_f_ff, rem_f_in, rem_t_ff, rem_t_in;
   logic [NUM_W-1:0] trial_f, trial_t;
   logic sat_f_ff, sat_t_ff;
   logic [CHI_W-1:0] q_f_ff, q_t_ff;
   logic ge_f, ge_t;
   logic [STEP_W-1:0] step_ff;
   logic [SCORE_W-1:0] acc_ff, acc_in;

   logic out_valid_ff;
   logic [IDX_W-1:0] out_index_ff;
   logic out_inlier_ff, out_final_ff;
   logic [CHI_W-1:0] out_chi_f_ff, out_chi_t_ff;
   logic [SCORE_W-1:0] out_score_ff;

   logic out_free;
   logic [CHI_W-1:0] chi_f, chi_t;
   logic inlier;
   logic [CHI_W:0] gain;
   logic [SCORE_W:0] acc_sum;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.match_index = out_index_ff;
   assign rsp_chan.is_inlier = out_inlier_ff;
   assign rsp_chan.chi_from = out_chi_f_ff;
   assign rsp_chan.chi_to = out_chi_t_ff;
   assign rsp_chan.score_total = out_score_ff;
   assign rsp_chan.score_final = out_final_ff;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign pop = (state_ff == ST_IDLE) && queue_valid;

   assign trial_f = NUM_W'(entry_ff.norm_from) << step_ff;
   assign trial_t = NUM_W'(entry_ff.norm_to) << step_ff;
   assign ge_f = rem_f_ff >= trial_f;
   assign ge_t = rem_t_ff >= trial_t;
   assign rem_f_in = ge_f ? rem_f_ff - trial_f : rem_f_ff;
   assign rem_t_in = ge_t ? rem_t_ff - trial_t : rem_t_ff;

   always_comb begin
      chi_f = sat_f_ff ? CHI_MAX : q_f_ff;
      chi_t = sat_t_ff ? CHI_MAX : q_t_ff;
      inlier = (entry_ff.norm_from != '0) && (entry_ff.norm_to != '0)
            && (chi_f <= cfg.inlier_threshold) && (chi_t <= cfg.inlier_threshold);
      gain = '0;
      if (chi_f < cfg.score_offset) begin
         gain = gain + (CHI_W+1)'(cfg.score_offset - chi_f);
      end
      if (chi_t < cfg.score_offset) begin
         gain = gain + (CHI_W+1)'(cfg.score_offset - chi_t);
      end
      acc_sum = (SCORE_W+1)'(acc_ff) + (SCORE_W+1)'(gain);
      acc_in = acc_ff;
      if (inlier) begin
         acc_in = (acc_sum > (SCORE_W+1)'(SCORE_MAX)) ? SCORE_MAX : acc_sum[SCORE_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (queue_valid) begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_SUM;
         ST_SUM: state_in = ST_SAT;
         ST_SAT: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         acc_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && out_free) begin
            acc_ff <= entry_ff.last ? '0 : acc_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end

      if (pop) begin
         entry_ff <= queue_entry;
         index_ff <= queue_index;
      end
      if (state_ff == ST_MUL_LO) begin
         prod_lo_ff <= entry_ff.r2[HALF_W-1:0] * cfg.inverse_sigma_squared;
      end
      if (state_ff == ST_MUL_HI) begin
         prod_hi_ff <= entry_ff.r2[R2_W-1:HALF_W] * cfg.inverse_sigma_squared;
      end
      if (state_ff == ST_SUM) begin
         num_ff <= NUM_W'(prod_lo_ff) + (NUM_W'(prod_hi_ff) << HALF_W);
      end
      if (state_ff == ST_SAT) begin
         sat_f_ff <= num_ff >= (NUM_W'(entry_ff.norm_from) << CHI_W);
         sat_t_ff <= num_ff >= (NUM_W'(entry_ff.norm_to) << CHI_W);
         rem_f_ff <= num_ff;
         rem_t_ff <= num_ff;
         step_ff <= STEP_W'(CHI_W - 1);
         q_f_ff <= '0;
         q_t_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         rem_f_ff <= rem_f_in;
         rem_t_ff <= rem_t_in;
         q_f_ff <= {q_f_ff[CHI_W-2:0], ge_f};
         q_t_ff <= {q_t_ff[CHI_W-2:0], ge_t};
         step_ff <= step_ff - 1'b1;
      end
      if (state_ff == ST_DONE && out_free) begin
         out_index_ff <= index_ff;
         out_inlier_ff <= inlier;
         out_chi_f_ff <= chi_f;
         out_chi_t_ff <= chi_t;
         out_score_ff <= acc_in;
         out_final_ff <= entry_ff.last;
      end
   end

endmodule

// ===== rtl/core/epipolar_inlier_scoring.sv =====
// Scores one essential-matrix hypothesis against a stream of point matches and returns one
// result per match, in order. The front end is a five-stage pipeline that forms both
// epipolar lines, the residual and the line norms; a two-entry queue separates it from the
// back end, which scales the squared residual and runs two 18-step restoring dividers in
// parallel. Each match passes in turn through a load, two partial multiplies, a sum, a
// saturation check, 18 divide steps and a scoring step; the back end takes the next match
// from the queue only after the previous result has gone to the output register. The score
// accumulator clears after each match marked last. Configuration writes take effect at once
// and must be made while no match is in flight.
module epipolar_inlier_scoring import epi_pkg::*; #(
   parameter int POINT_INDEX_LIMIT = POINT_INDEX_LIMIT_DEFAULT,
   parameter int IDX_W = $clog2(POINT_INDEX_LIMIT)
) (
   input logic clock,
   input logic reset,
   epi_req_if.sink req_chan,
   epi_rsp_if.source rsp_chan,
   input logic csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [ROW_W-1:0] csr_wdata
);

   logic [ROW_W-1:0] e_row_ff [3];
   score_cfg_type cfg_ff;

   logic push, queue_full, pop, queue_valid;
   line_entry_type push_entry, queue_entry;
   logic [IDX_W-1:0] push_index, queue_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_row_ff[0] <= '0;
         e_row_ff[1] <= '0;
         e_row_ff[2] <= '0;
         cfg_ff.inverse_sigma_squared <= SCALE_RESET;
         cfg_ff.inlier_threshold <= THRESHOLD_RESET;
         cfg_ff.score_offset <= OFFSET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_E_ROW0: e_row_ff[0] <= csr_wdata;
            CSR_E_ROW1: e_row_ff[1] <= csr_wdata;
            CSR_E_ROW2: e_row_ff[2] <= csr_wdata;
            CSR_INV_SIGMA_SQ: cfg_ff.inverse_sigma_squared <= csr_wdata[SCALE_W-1:0];
            CSR_THRESHOLD: cfg_ff.inlier_threshold <= csr_wdata[CHI_W-1:0];
            CSR_SCORE_OFFSET: cfg_ff.score_offset <= csr_wdata[CHI_W-1:0];
            default: begin
            end
         endcase
      end
   end

   epi_front #(.IDX_W(IDX_W)) u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .e_row(e_row_ff),
      .push(push),
      .push_entry(push_entry),
      .push_index(push_index),
      .queue_full(queue_full)
   );

   epi_fifo #(.WIDTH($bits(line_entry_type) + IDX_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data({push_index, push_entry}),
      .full(queue_full),
      .pop(pop),
      .pop_data({queue_index, queue_entry}),
      .not_empty(queue_valid)
   );

   epi_back #(.IDX_W(IDX_W)) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .queue_valid(queue_valid),
      .queue_entry(queue_entry),
      .queue_index(queue_index),
      .pop(pop),
      .rsp_chan(rsp_chan)
   );

endmodule
